// ----- design/ramdac_registers_and_cursor_overlay_assert.svh -----
// ----------------------------------------------------------------------------
// ramdac_registers_and_cursor_overlay_assert.svh
// Assertion macros used by the RAMDAC register and cursor block.
// ----------------------------------------------------------------------------
`ifndef RAMDAC_REGISTERS_AND_CURSOR_OVERLAY_ASSERT_SVH
`define RAMDAC_REGISTERS_AND_CURSOR_OVERLAY_ASSERT_SVH

// same-cycle implication, masked during reset
`define RDCO_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdco: same-cycle check failed");

// next-cycle implication, masked during reset
`define RDCO_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdco: next-cycle check failed");

`endif

// ----- design/rdco_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdco_pkg
// Types and constants of the RAMDAC register and cursor overlay block.
// ----------------------------------------------------------------------------
package rdco_pkg;

  // request op codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  // bus ports
  localparam logic [1:0] PORT_INDEX  = 2'd0;
  localparam logic [1:0] PORT_CURPAL = 2'd1;
  localparam logic [1:0] PORT_REG    = 2'd2;
  localparam logic [1:0] PORT_PAL    = 2'd3;

  // indexed register map
  localparam logic [7:0] IX_POS_LO = 8'd0;
  localparam logic [7:0] IX_POS_HI = 8'd1;
  localparam logic [7:0] IX_MISC   = 8'd2;
  localparam logic [7:0] IX_CLKSEL = 8'd5;
  localparam logic [7:0] IX_ID     = 8'd10;

  // configuration space
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned SCREEN_W_W = 13;
  localparam logic [SCREEN_W_W-1:0] SCREEN_WIDTH_RESET = 13'd640;

  // front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    K_NOP       = 3'd0,
    K_READ_REG  = 3'd1,
    K_WR_INDEX  = 3'd2,
    K_WR_CURPAL = 3'd3,
    K_WR_REG    = 3'd4,
    K_WR_PAL    = 3'd5,
    K_PIXEL     = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  wdata;
    logic [11:0] pixel_x;
    logic [3:0]  cursor_code;
    logic [23:0] back_color;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        palette_write;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
    logic        cursor_change;
    logic        cursor_on;
    logic [23:0] pixel_color;
  } result_t;

endpackage

// ----- design/rdco_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdco_if
// Request and result channels (valid/ready with payload).
// ----------------------------------------------------------------------------
interface rdco_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  port;
  logic [7:0]  wdata;
  logic [11:0] pixel_x;
  logic [3:0]  cursor_code;
  logic [23:0] back_color;

  modport source (output valid, op, port, wdata, pixel_x, cursor_code, back_color,
                  input ready);
  modport sink   (input valid, op, port, wdata, pixel_x, cursor_code, back_color,
                  output ready);
endinterface

interface rdco_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        palette_write;
  logic [7:0]  palette_index;
  logic [23:0] palette_rgb;
  logic        cursor_change;
  logic        cursor_on;
  logic [23:0] pixel_color;

  modport source (output valid, read_data, palette_write, palette_index, palette_rgb,
                  cursor_change, cursor_on, pixel_color, input ready);
  modport sink   (input valid, read_data, palette_write, palette_index, palette_rgb,
                  cursor_change, cursor_on, pixel_color, output ready);
endinterface

// ----- design/rdco_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdco_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module rdco_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rdco_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rdco_pkg::cmd_t pop_data
);

  rdco_pkg::cmd_t                      entry [rdco_pkg::QUEUE_DEPTH];
  logic [rdco_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [rdco_pkg::QUEUE_PTR_W-1:0]    rd_ptr;
  logic [rdco_pkg::QUEUE_CNT_W-1:0]    count;
  logic [rdco_pkg::QUEUE_CNT_W-1:0]    count_next;
  logic                                push;
  logic                                pop;

  assign push_ready = (count != rdco_pkg::QUEUE_CNT_W'(rdco_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry[rd_ptr];
  assign count_next = count + rdco_pkg::QUEUE_CNT_W'(push)
                            - rdco_pkg::QUEUE_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- design/rdco_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdco_front
// Takes requests and sorts each into one kind of back-end command.
// ----------------------------------------------------------------------------
module rdco_front (
  rdco_req_if.sink        req,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output rdco_pkg::cmd_t  cmd
);

  rdco_pkg::kind_t kind;

  always_comb begin
    kind = rdco_pkg::K_NOP;
    case (req.op)
      rdco_pkg::OP_READ: begin
        // only the indexed port reads back anything
        if (req.port == rdco_pkg::PORT_REG) begin
          kind = rdco_pkg::K_READ_REG;
        end
      end
      rdco_pkg::OP_WRITE: begin
        case (req.port)
          rdco_pkg::PORT_INDEX:  kind = rdco_pkg::K_WR_INDEX;
          rdco_pkg::PORT_CURPAL: kind = rdco_pkg::K_WR_CURPAL;
          rdco_pkg::PORT_REG:    kind = rdco_pkg::K_WR_REG;
          default:               kind = rdco_pkg::K_WR_PAL;
        endcase
      end
      rdco_pkg::OP_PIXEL: kind = rdco_pkg::K_PIXEL;
      default:            kind = rdco_pkg::K_NOP;
    endcase
  end

  assign cmd_valid       = req.valid;
  assign req.ready       = cmd_ready;
  assign cmd.kind        = kind;
  assign cmd.wdata       = req.wdata;
  assign cmd.pixel_x     = req.pixel_x;
  assign cmd.cursor_code = req.cursor_code;
  assign cmd.back_color  = req.back_color;

endmodule

// ----- design/rdco_back.sv -----
`timescale 1ns / 1ps
`include "ramdac_registers_and_cursor_overlay_assert.svh"
// ----------------------------------------------------------------------------
// rdco_back
// Executes commands against the register state, composites pixels and
// holds each result in the output register.
// ----------------------------------------------------------------------------
module rdco_back #(
  parameter int unsigned CURSOR_WIDTH  = 32,
  parameter int unsigned CURSOR_COLORS = 8,
  parameter int unsigned ID_VALUE      = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  rdco_pkg::cmd_t                     cmd,
  input  logic [rdco_pkg::SCREEN_W_W-1:0]    screen_width,
  rdco_rsp_if.source                         rsp
);

  localparam int unsigned SLOT_W = $clog2(CURSOR_COLORS);
  localparam logic [15:0] CURSOR_W_V = 16'(CURSOR_WIDTH);
  localparam logic [7:0]  ID_V       = 8'(ID_VALUE);

  logic [7:0]  reg_index;
  logic [1:0]  component_count;
  logic [7:0]  hold0;
  logic [7:0]  hold1;
  logic [23:0] cursor_palette [CURSOR_COLORS];
  logic [15:0] cursor_x;
  logic [7:0]  cursor_x_low_latch;
  logic [7:0]  misc_control;
  logic [7:0]  clock_select;

  logic                    out_valid;
  rdco_pkg::result_t       result;
  rdco_pkg::result_t       result_next;
  logic                    pop;
  logic                    byte_done;
  logic [23:0]             rgb;
  logic [SLOT_W-1:0]       slot_of [256];
  logic [SLOT_W-1:0]       wr_slot;
  logic [SLOT_W-1:0]       color_slot;
  logic [15:0]             px_wide;
  logic [15:0]             px_offset;
  logic                    in_window;
  logic [23:0]             inverted;

  // residue of every byte value modulo the colour count, a constant table
  always_comb begin
    for (int i = 0; i < 256; i++) begin
      slot_of[i] = SLOT_W'(i % CURSOR_COLORS);
    end
  end

  assign cmd_ready  = !out_valid || rsp.ready;
  assign pop        = cmd_valid && cmd_ready;
  assign byte_done  = (component_count == 2'd2);
  assign rgb        = {hold0, hold1, cmd.wdata};
  assign wr_slot    = slot_of[reg_index];
  assign color_slot = slot_of[{5'd0, cmd.cursor_code[2:0]}];
  assign px_wide    = {4'd0, cmd.pixel_x};
  assign px_offset  = px_wide - cursor_x;
  assign in_window  = ({1'b0, cmd.pixel_x} < screen_width) && (px_wide >= cursor_x)
                      && (px_offset < CURSOR_W_V);
  // each channel: 00 where its MSB is set, FF where clear
  assign inverted   = {{8{~cmd.back_color[23]}}, {8{~cmd.back_color[15]}},
                       {8{~cmd.back_color[7]}}};

  always_comb begin
    result_next = '0;
    case (cmd.kind)
      rdco_pkg::K_READ_REG: begin
        case (reg_index)
          rdco_pkg::IX_MISC:   result_next.read_data = misc_control;
          rdco_pkg::IX_CLKSEL: result_next.read_data = clock_select;
          rdco_pkg::IX_ID:     result_next.read_data = ID_V;
          default:             result_next.read_data = 8'd0;
        endcase
      end
      rdco_pkg::K_WR_REG: begin
        if ((reg_index == rdco_pkg::IX_MISC) && (misc_control[1] != cmd.wdata[1])) begin
          result_next.cursor_change = 1'b1;
          result_next.cursor_on     = cmd.wdata[1];
        end
      end
      rdco_pkg::K_WR_PAL: begin
        if (byte_done) begin
          result_next.palette_write = 1'b1;
          result_next.palette_index = reg_index;
          result_next.palette_rgb   = rgb;
        end
      end
      rdco_pkg::K_PIXEL: begin
        if (!in_window) begin
          result_next.pixel_color = cmd.back_color;
        end else if (cmd.cursor_code[3]) begin
          result_next.pixel_color = cursor_palette[color_slot];
        end else if (cmd.cursor_code[0]) begin
          result_next.pixel_color = inverted;
        end else begin
          result_next.pixel_color = cmd.back_color;
        end
      end
      default: result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index          <= '0;
      component_count    <= '0;
      hold0              <= '0;
      hold1              <= '0;
      cursor_x           <= '0;
      cursor_x_low_latch <= '0;
      misc_control       <= '0;
      clock_select       <= '0;
      for (int i = 0; i < CURSOR_COLORS; i++) begin
        cursor_palette[i] <= '0;
      end
    end else if (pop) begin
      case (cmd.kind)
        rdco_pkg::K_WR_INDEX: reg_index <= cmd.wdata;
        rdco_pkg::K_WR_CURPAL, rdco_pkg::K_WR_PAL: begin
          // both data ports share one byte collector
          if (byte_done) begin
            component_count <= '0;
            reg_index       <= reg_index + 8'd1;
            if (cmd.kind == rdco_pkg::K_WR_CURPAL) begin
              cursor_palette[wr_slot] <= rgb;
            end
          end else begin
            component_count <= component_count + 2'd1;
            if (component_count == 2'd0) begin
              hold0 <= cmd.wdata;
            end else begin
              hold1 <= cmd.wdata;
            end
          end
        end
        rdco_pkg::K_WR_REG: begin
          // writes to any other index have no effect here
          case (reg_index)
            rdco_pkg::IX_POS_LO: cursor_x_low_latch <= cmd.wdata;
            rdco_pkg::IX_POS_HI: cursor_x <= {cmd.wdata, cursor_x_low_latch};
            rdco_pkg::IX_MISC:   misc_control <= cmd.wdata;
            rdco_pkg::IX_CLKSEL: clock_select <= cmd.wdata;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ready) begin
      out_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = result.read_data;
  assign rsp.palette_write = result.palette_write;
  assign rsp.palette_index = result.palette_index;
  assign rsp.palette_rgb   = result.palette_rgb;
  assign rsp.cursor_change = result.cursor_change;
  assign rsp.cursor_on     = result.cursor_on;
  assign rsp.pixel_color   = result.pixel_color;

  `RDCO_ASSERT_NXT(a_index_load, clk, rst, pop && (cmd.kind == rdco_pkg::K_WR_INDEX), reg_index == $past(cmd.wdata))
  `RDCO_ASSERT_NXT(a_pal_done, clk, rst, pop && (cmd.kind == rdco_pkg::K_WR_PAL) && byte_done, out_valid && result.palette_write && (component_count == 2'd0))
  `RDCO_ASSERT_IMP(a_cursor_on, clk, rst, out_valid && result.cursor_change, result.cursor_on == misc_control[1])

endmodule

// ----- design/ramdac_registers_and_cursor_overlay.sv -----
`timescale 1ns / 1ps
// Path: an accepted request passes through a queue slot, then the output
// register, which holds the result until the result sink takes it.
// Throughput: one request per cycle while the result sink is ready; set
// by the back end's single execute stage, which updates state per command.
// Reset: synchronous, active high; all registers but queue and result data
// clear to 0, screen_width to 640; no clearing pass, requests taken now.
// ----------------------------------------------------------------------------
// ramdac_registers_and_cursor_overlay
// Video DAC register file with palette collection and a hardware cursor
// overlay on the pixel stream; APB port for the screen width.
// ----------------------------------------------------------------------------
module ramdac_registers_and_cursor_overlay #(
  parameter int unsigned CURSOR_WIDTH  = 32,
  parameter int unsigned CURSOR_COLORS = 8,
  parameter int unsigned ID_VALUE      = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  rdco_req_if.sink                          req,
  rdco_rsp_if.source                        rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rdco_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rdco_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rdco_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  // Request path:
  //   front  - decodes op/port into a command kind, no storage
  //   queue  - two-entry FIFO; lets a stalled result sink hold the back end
  //            without stopping request acceptance straight away
  //   back   - register state, byte collector, cursor palette and the
  //            pixel compositor, followed by the output register

  logic                               q_in_valid;
  logic                               q_in_ready;
  rdco_pkg::cmd_t                     q_in_cmd;
  logic                               q_out_valid;
  logic                               q_out_ready;
  rdco_pkg::cmd_t                     q_out_cmd;
  logic [rdco_pkg::SCREEN_W_W-1:0]    screen_width;
  logic                               cfg_write;
  logic                               cfg_hit;

  rdco_front u_front (
    .req       (req),
    .cmd_valid (q_in_valid),
    .cmd_ready (q_in_ready),
    .cmd       (q_in_cmd)
  );

  rdco_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_cmd),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_cmd)
  );

  rdco_back #(
    .CURSOR_WIDTH  (CURSOR_WIDTH),
    .CURSOR_COLORS (CURSOR_COLORS),
    .ID_VALUE      (ID_VALUE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_out_valid),
    .cmd_ready    (q_out_ready),
    .cmd          (q_out_cmd),
    .screen_width (screen_width),
    .rsp          (rsp)
  );

  // APB: one register, screen_width, at byte address 0. Word select is
  // paddr[2]; the byte-lane bits are ignored. pready is tied high, so no waits.
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[2] == 1'b0);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= rdco_pkg::SCREEN_WIDTH_RESET;
    end else if (cfg_write && cfg_hit) begin
      screen_width <= pwdata[rdco_pkg::SCREEN_W_W-1:0];
    end
  end

  // read-back; anything outside the register reads as zero
  assign prdata = cfg_hit ? rdco_pkg::APB_DATA_W'(screen_width) : '0;

endmodule
